FILE: rtl/core/bbce_pkg.sv
// Shared types and constants for the clamped-edge box blur.
// Used by the sequencer, datapath and top level; depends on nothing.
`timescale 1ns / 1ps

package bbce_pkg;

    // Register map of the configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;

    // Register widths and reset values
    localparam int RADIUS_W = 6;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 16;
    localparam int CHAN_W   = 3;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
    localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd3;

    // Pixel layout and arithmetic
    localparam int NUM_CH    = 4;
    localparam int BYTE_W    = 8;
    localparam int PIX_W     = NUM_CH * BYTE_W;
    localparam int ROW_W     = 17;            // stream row incl. drain rows
    localparam int QUOT_W    = 8;             // mean of bytes fits one byte
    localparam int DSTEP_W   = 3;
    localparam logic [DSTEP_W-1:0] DSTEP_FIRST = 3'd7;

    // Word kinds on the input channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [CHAN_W-1:0]   chans;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take the input word
        logic col_rd;     // one line store read for the column sum
        logic col_wr;     // store column sum, set up output range
        logic win_start;  // set up window update for current column
        logic win_rd;     // one column sum read for the window
        logic div_start;  // load divider
        logic div_step;   // one quotient bit per lane
        logic out_set;    // load output word
        logic out_next;   // advance to next output column
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic kind_ok;
        logic col_last;
        logic emit;
        logic win_last;
        logic div_last;
        logic ox_last;
    } t_sts;

endpackage

FILE: rtl/core/bbce_ctrl.sv
// Sequencer of the box blur: steps one input word through column sum and,
// if it yields results, window update, division and output. Depends on bbce_pkg.
`timescale 1ns / 1ps

module bbce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  bbce_pkg::t_sts  i_sts,
    output bbce_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_COL, S_COLW, S_COLST, S_WSET, S_WIN, S_WINW,
        S_DSET, S_DIV, S_OSET, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.kind_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COL;
                end
            end
            S_COL: begin
                o_cmd.col_rd = 1'b1;
                if (i_sts.col_last) n_state = S_COLW;
            end
            S_COLW:  n_state = S_COLST;
            S_COLST: begin
                o_cmd.col_wr = 1'b1;
                n_state      = i_sts.emit ? S_WSET : S_IDLE;
            end
            S_WSET: begin
                o_cmd.win_start = 1'b1;
                n_state         = S_WIN;
            end
            S_WIN: begin
                o_cmd.win_rd = 1'b1;
                if (i_sts.win_last) n_state = S_WINW;
            end
            S_WINW: n_state = S_DSET;
            S_DSET: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OSET;
            end
            S_OSET: begin
                o_cmd.out_set = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_sts.ox_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_WSET;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

FILE: rtl/core/bbce_dp.sv
// Datapath of the box blur: line store, column sum memory, window sums,
// bit-serial dividers and the output word. Depends on bbce_pkg.
`timescale 1ns / 1ps

module bbce_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbce_pkg::t_cfg              i_cfg,
    input  logic                        i_restart,
    input  bbce_pkg::t_cmd              i_cmd,
    output bbce_pkg::t_sts              o_sts,
    input  logic                        i_kind,
    input  logic [bbce_pkg::BYTE_W-1:0] i_chan0,
    input  logic [bbce_pkg::BYTE_W-1:0] i_chan1,
    input  logic [bbce_pkg::BYTE_W-1:0] i_chan2,
    input  logic [bbce_pkg::BYTE_W-1:0] i_chan3,
    output logic [bbce_pkg::BYTE_W-1:0] o_out0,
    output logic [bbce_pkg::BYTE_W-1:0] o_out1,
    output logic [bbce_pkg::BYTE_W-1:0] o_out2,
    output logic [bbce_pkg::BYTE_W-1:0] o_out3,
    output logic                        o_last_of_run,
    output logic                        o_end_of_frame
);

    localparam int LR       = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W   = $clog2(LR);
    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int X_EW     = (XW > bbce_pkg::WIDTH_W) ? XW : bbce_pkg::WIDTH_W;
    localparam int SC_W     = X_EW + 2;
    localparam int LS_DEPTH = LR * MAX_WIDTH;
    localparam int LA_W     = $clog2(LS_DEPTH);
    localparam int CS_W     = $clog2(LR * 255 + 1);
    localparam int WS_W     = $clog2(LR * LR * 255 + 1);
    localparam int DV_W     = $clog2(LR * LR + 1);
    localparam int TW       = WS_W + bbce_pkg::QUOT_W;
    localparam int T_W      = bbce_pkg::ROW_W + 1;
    localparam int NC       = bbce_pkg::NUM_CH;
    localparam int BW       = bbce_pkg::BYTE_W;
    localparam int RW       = bbce_pkg::ROW_W;
    localparam int RDW      = bbce_pkg::RADIUS_W;

    // Memories
    logic [bbce_pkg::PIX_W-1:0] line_mem [LS_DEPTH];
    logic [NC*CS_W-1:0]         cs_mem   [MAX_WIDTH];

    // Input position and current word
    logic [XW-1:0]     r_x, r_cx;
    logic [RW-1:0]     r_s, r_cs;
    logic [SLOT_W-1:0] r_slot_s;
    // Column sum walk
    logic signed [T_W-1:0] r_t;
    logic [SLOT_W-1:0]     r_slot;
    logic [RDW:0]          r_cnt;
    logic                  r_col_v;
    logic [bbce_pkg::PIX_W-1:0] r_ls_q;
    logic [CS_W-1:0]       r_colacc [NC];
    // Window
    logic [XW-1:0]          r_ox, r_hi;
    logic                   r_full;
    logic signed [SC_W-1:0] r_c;
    logic [RDW:0]           r_wc;
    logic                   r_win_v, r_win_sub;
    logic [NC*CS_W-1:0]     r_cs_q;
    logic [WS_W-1:0]        r_win [NC];
    // Divider
    logic [DV_W-1:0]              r_div;
    logic [WS_W-1:0]              r_rem [NC];
    logic [bbce_pkg::QUOT_W-1:0]  r_q   [NC];
    logic [bbce_pkg::DSTEP_W-1:0] r_dstep;
    // Output word
    logic [BW-1:0] r_out [NC];
    logic          r_last, r_eof;

    // Derived config values
    logic [RDW:0]      two_r;
    logic [X_EW-1:0]   w_m1;
    logic [RW-1:0]     h_rw;
    logic [RW-1:0]     r_rw;
    logic [X_EW-1:0]   r_xe;
    assign two_r = {i_cfg.radius, 1'b0};
    assign w_m1  = X_EW'(i_cfg.width) - X_EW'(1);
    assign h_rw  = RW'(i_cfg.height);
    assign r_rw  = RW'(i_cfg.radius);
    assign r_xe  = X_EW'(i_cfg.radius);

    function automatic logic [SLOT_W-1:0] f_wrap(input logic [SLOT_W-1:0] v,
                                                 input logic [RDW:0] lim);
        if ((RDW+1)'(v) == lim) return '0;
        return v + SLOT_W'(1);
    endfunction

    function automatic logic [XW-1:0] f_clamp(input logic signed [SC_W-1:0] c,
                                              input logic [X_EW-1:0] wm1);
        logic signed [SC_W-1:0] lim;
        lim = $signed(SC_W'(wm1));
        if (c < 0) return '0;
        if (c > lim) return XW'(wm1);
        return XW'(c);
    endfunction

    // Pixel packing
    logic [bbce_pkg::PIX_W-1:0] pix;
    assign pix = {i_chan3, i_chan2, i_chan1, i_chan0};

    // Load-time helpers
    logic                  x_at_end;
    logic [RW-1:0]         s_inc;
    logic signed [T_W-1:0] top;
    assign x_at_end = (X_EW'(r_x) == w_m1);
    assign s_inc    = r_s + RW'(1);
    assign top      = $signed({1'b0, r_s}) - $signed(T_W'(two_r));

    // Column walk: next row, clamped to the frame
    logic signed [T_W-1:0] t_nx;
    logic                  t_in;
    assign t_nx = r_t + T_W'(1);
    assign t_in = (t_nx > 0) && (t_nx <= $signed(T_W'(i_cfg.height)) - T_W'(1));

    // Output range of the current word
    logic cx_end, cx_ge_r;
    logic [XW-1:0] lo, hi;
    assign cx_end  = (X_EW'(r_cx) == w_m1);
    assign cx_ge_r = (X_EW'(r_cx) >= r_xe);
    always_comb begin
        if (cx_end) begin
            lo = cx_ge_r ? r_cx - XW'(i_cfg.radius) : '0;
            hi = XW'(w_m1);
        end else begin
            lo = r_cx - XW'(i_cfg.radius);
            hi = lo;
        end
    end

    // Window read address
    logic [XW-1:0] win_addr;
    always_comb begin
        if (r_full) begin
            win_addr = f_clamp(r_c, w_m1);
        end else if (r_wc == '0) begin
            win_addr = f_clamp($signed(SC_W'(r_ox)) + $signed(SC_W'(i_cfg.radius)), w_m1);
        end else begin
            win_addr = f_clamp($signed(SC_W'(r_ox)) - SC_W'(1)
                               - $signed(SC_W'(i_cfg.radius)), w_m1);
        end
    end

    // Status
    assign o_sts.kind_ok  = (i_kind == ((r_s >= h_rw) ? bbce_pkg::KIND_DRAIN
                                                      : bbce_pkg::KIND_PIXEL));
    assign o_sts.col_last = (r_cnt == two_r);
    assign o_sts.emit     = (r_cs >= r_rw) && (cx_end || cx_ge_r);
    assign o_sts.win_last = r_full ? (r_wc == two_r) : (r_wc == (RDW+1)'(1));
    assign o_sts.div_last = (r_dstep == '0);
    assign o_sts.ox_last  = (r_ox == r_hi);

    // Line store: pixel write on load, column reads
    logic [LA_W-1:0] ls_wa, ls_ra;
    assign ls_wa = LA_W'(r_slot_s) * LA_W'(MAX_WIDTH) + LA_W'(r_x);
    assign ls_ra = LA_W'(r_slot) * LA_W'(MAX_WIDTH) + LA_W'(r_cx);
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (i_kind == bbce_pkg::KIND_PIXEL)) begin
            line_mem[ls_wa] <= pix;
        end
        r_ls_q <= line_mem[ls_ra];
    end

    // Column sum memory
    logic [NC*CS_W-1:0] cs_wd;
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            cs_wd[k*CS_W +: CS_W] = r_colacc[k];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.col_wr) begin
            cs_mem[r_cx] <= cs_wd;
        end
        r_cs_q <= cs_mem[win_addr];
    end

    // Control registers: position, read flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_s       <= '0;
            r_slot_s  <= '0;
            r_col_v   <= 1'b0;
            r_win_v   <= 1'b0;
            r_win_sub <= 1'b0;
        end else begin
            r_col_v   <= i_cmd.col_rd;
            r_win_v   <= i_cmd.win_rd;
            r_win_sub <= i_cmd.win_rd && !r_full && (r_wc != '0);
            if (i_restart) begin
                r_x      <= '0;
                r_s      <= '0;
                r_slot_s <= '0;
            end else if (i_cmd.load) begin
                if (x_at_end) begin
                    r_x <= '0;
                    if (s_inc >= h_rw + r_rw) begin
                        r_s      <= '0;
                        r_slot_s <= '0;
                    end else begin
                        r_s      <= s_inc;
                        r_slot_s <= f_wrap(r_slot_s, two_r);
                    end
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        // word setup
        if (i_cmd.load) begin
            r_cx   <= r_x;
            r_cs   <= r_s;
            r_t    <= top;
            r_slot <= (top < 0) ? '0 : f_wrap(r_slot_s, two_r);
            r_cnt  <= '0;
            r_div  <= DV_W'(14'(two_r + (RDW+1)'(1)) * 14'(two_r + (RDW+1)'(1)));
        end
        // column walk
        if (i_cmd.col_rd) begin
            r_t   <= t_nx;
            r_cnt <= r_cnt + (RDW+1)'(1);
            if (t_in) r_slot <= f_wrap(r_slot, two_r);
        end
        for (int k = 0; k < NC; k++) begin
            if (i_cmd.load) begin
                r_colacc[k] <= '0;
            end else if (r_col_v) begin
                r_colacc[k] <= r_colacc[k] + CS_W'(r_ls_q[k*BW +: BW]);
            end
        end
        // output range
        if (i_cmd.col_wr) begin
            r_ox <= lo;
            r_hi <= hi;
        end else if (i_cmd.out_next) begin
            r_ox <= r_ox + XW'(1);
        end
        // window
        if (i_cmd.win_start) begin
            r_full <= (r_ox == '0);
            r_wc   <= '0;
            r_c    <= -$signed(SC_W'(i_cfg.radius));
        end
        if (i_cmd.win_rd) begin
            r_wc <= r_wc + (RDW+1)'(1);
            r_c  <= r_c + SC_W'(1);
        end
        for (int k = 0; k < NC; k++) begin
            if (i_cmd.win_start && (r_ox == '0)) begin
                r_win[k] <= '0;
            end else if (r_win_v) begin
                if (r_win_sub) r_win[k] <= r_win[k] - WS_W'(r_cs_q[k*CS_W +: CS_W]);
                else           r_win[k] <= r_win[k] + WS_W'(r_cs_q[k*CS_W +: CS_W]);
            end
        end
        // restoring division, one quotient bit per step
        if (i_cmd.div_start) begin
            r_dstep <= bbce_pkg::DSTEP_FIRST;
        end else if (i_cmd.div_step) begin
            r_dstep <= r_dstep - bbce_pkg::DSTEP_W'(1);
        end
        for (int k = 0; k < NC; k++) begin
            if (i_cmd.div_start) begin
                r_rem[k] <= r_win[k];
                r_q[k]   <= '0;
            end else if (i_cmd.div_step) begin
                if (TW'(r_rem[k]) >= (TW'(r_div) << r_dstep)) begin
                    r_rem[k]          <= WS_W'(TW'(r_rem[k]) - (TW'(r_div) << r_dstep));
                    r_q[k][r_dstep]   <= 1'b1;
                end
            end
        end
        // output word
        if (i_cmd.out_set) begin
            for (int k = 0; k < NC; k++) begin
                r_out[k] <= (bbce_pkg::CHAN_W'(k) < i_cfg.chans) ? r_q[k] : '0;
            end
            r_last <= (r_ox == r_hi);
            r_eof  <= ((r_cs - r_rw) == (h_rw - RW'(1))) && (X_EW'(r_ox) == w_m1);
        end
    end

    assign o_out0         = r_out[0];
    assign o_out1         = r_out[1];
    assign o_out2         = r_out[2];
    assign o_out3         = r_out[3];
    assign o_last_of_run  = r_last;
    assign o_end_of_frame = r_eof;

endmodule

FILE: rtl/core/box_blur_clamped_edges.sv
// Top level of the clamped-edge box blur: configuration registers,
// sequencer and datapath. Depends on bbce_pkg, bbce_ctrl, bbce_dp.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_kind, i_chan0..i_chan3
//  out     | out       | o_out_valid / i_out_stall | o_out0..3, o_last_of_run,
//          |           |                           | o_end_of_frame
//  cfg     | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  One word at a time. Each word reads the line store once per window row, and
//  each result then reads 2r+1 (first column) or 2 column sums, passes setup
//  and a bit-serial division, and holds its output word until it is taken.
//  The line store and column sum memory have one read port each.
//  Reset clears position and resets config; memories are always written before read.
//  A stalled result holds the block; o_in_stall is high while any work runs.

module box_blur_clamped_edges #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_RADIUS   = 32,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_kind,
    input  logic [7:0]                      i_chan0,
    input  logic [7:0]                      i_chan1,
    input  logic [7:0]                      i_chan2,
    input  logic [7:0]                      i_chan3,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out0,
    output logic [7:0]                      o_out1,
    output logic [7:0]                      o_out2,
    output logic [7:0]                      o_out3,
    output logic                            o_last_of_run,
    output logic                            o_end_of_frame
);

    bbce_pkg::t_cfg r_cfg;
    bbce_pkg::t_cmd cmd;
    bbce_pkg::t_sts sts;

    logic [bbce_pkg::RADIUS_W-1:0] v_rad;
    logic [bbce_pkg::WIDTH_W-1:0]  v_wid;
    logic [bbce_pkg::HEIGHT_W-1:0] v_hgt;
    logic [bbce_pkg::CHAN_W-1:0]   v_chn;
    assign v_rad = i_cfg_data[bbce_pkg::RADIUS_W-1:0];
    assign v_wid = i_cfg_data[bbce_pkg::WIDTH_W-1:0];
    assign v_hgt = i_cfg_data[bbce_pkg::HEIGHT_W-1:0];
    assign v_chn = i_cfg_data[bbce_pkg::CHAN_W-1:0];

    // Configuration registers, saturated on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius <= bbce_pkg::RADIUS_RST;
            r_cfg.width  <= bbce_pkg::WIDTH_RST;
            r_cfg.height <= bbce_pkg::HEIGHT_RST;
            r_cfg.chans  <= bbce_pkg::CHAN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbce_pkg::REG_RADIUS:
                    r_cfg.radius <= (int'(v_rad) > MAX_RADIUS)
                                    ? bbce_pkg::RADIUS_W'(MAX_RADIUS) : v_rad;
                bbce_pkg::REG_WIDTH:
                    r_cfg.width <= (v_wid == '0) ? bbce_pkg::WIDTH_W'(1)
                                 : (int'(v_wid) > MAX_WIDTH)
                                   ? bbce_pkg::WIDTH_W'(MAX_WIDTH) : v_wid;
                bbce_pkg::REG_HEIGHT:
                    r_cfg.height <= (v_hgt == '0) ? bbce_pkg::HEIGHT_W'(1) : v_hgt;
                bbce_pkg::REG_CHANNELS:
                    r_cfg.chans <= (v_chn == '0) ? bbce_pkg::CHAN_W'(1)
                                 : (int'(v_chn) > MAX_CHANNELS)
                                   ? bbce_pkg::CHAN_W'(MAX_CHANNELS) : v_chn;
                default: ;
            endcase
        end
    end

    bbce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bbce_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_restart      (i_cfg_we),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_chan0        (i_chan0),
        .i_chan1        (i_chan1),
        .i_chan2        (i_chan2),
        .i_chan3        (i_chan3),
        .o_out0         (o_out0),
        .o_out1         (o_out1),
        .o_out2         (o_out2),
        .o_out3         (o_out3),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

FILE: rtl/core/bbce_chk.sv
// Port-level checks of the box blur, bound to the top level.
// Depends on box_blur_clamped_edges ports only.
`timescale 1ns / 1ps

module bbce_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out0,
    input logic       o_last_of_run,
    input logic       o_end_of_frame
);

    // a held result keeps its o_out0 byte
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out0))
        else $error("result word changed under stall");

    // input side only opens when no result is pending
    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input open while result pending");

    // frame end is always the last result of its word
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("frame end without last of run");

    // each result needs fresh work after it is taken
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("back to back results");

endmodule

bind box_blur_clamped_edges bbce_chk u_bbce_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out0         (o_out0),
    .o_last_of_run  (o_last_of_run),
    .o_end_of_frame (o_end_of_frame)
);
